@@ rtl/mbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg: shared types, constants and channel math
// Sizes, configuration register indexes and the per-channel RGBA8 averaging
// helpers used by the box-filter downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int CNT_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 32;
  localparam int SUM_W      = 36;

  localparam logic [CFG_W-1:0] MAX_W_CFG = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] MAX_H_CFG = CFG_W'(MAX_HEIGHT);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;

  // Filter shape picked from the source size
  typedef enum logic [1:0] {
    MODE_QUAD,
    MODE_ROW,
    MODE_COL,
    MODE_PASS
  } mode_t;

  // Position info for the pixel at the head of the stream
  typedef struct packed {
    mode_t              mode;
    logic               x_odd;
    logic               y_odd;
    logic               col_keep;
    logic               row_keep;
    logic               last_x;
    logic               last_y;
    logic [LINE_AW-1:0] idx;
  } ctl_t;

  // Four 9-bit channel sums of two pixels, R lowest
  function automatic logic [SUM_W-1:0] add_pair(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int c = 0; c < 4; c++) begin
      s[9*c +: 9] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
    end
    return s;
  endfunction

  // Per-channel (a + b) >> 1
  function automatic logic [PIX_W-1:0] pair_avg(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0] s;
    logic [PIX_W-1:0] p;
    s = add_pair(a, b);
    p = '0;
    for (int c = 0; c < 4; c++) begin
      p[8*c +: 8] = s[9*c+1 +: 8];
    end
    return p;
  endfunction

  // Per-channel (sum of four) >> 2 from two pair sums
  function automatic logic [PIX_W-1:0] quad_avg(input logic [SUM_W-1:0] s0,
                                                 input logic [SUM_W-1:0] s1);
    logic [9:0]       v;
    logic [PIX_W-1:0] p;
    p = '0;
    for (int c = 0; c < 4; c++) begin
      v = {1'b0, s0[9*c +: 9]} + {1'b0, s1[9*c +: 9]};
      p[8*c +: 8] = v[9:2];
    end
    return p;
  endfunction

endpackage

@@ rtl/mbd_line_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_line_ram: single-port line buffer
// One write or one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module mbd_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/mbd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_ctrl: size registers and raster position
// Holds the source size, tracks column and row of the next pixel and
// classifies it for the datapath.
// ----------------------------------------------------------------------------
module mbd_ctrl
  import mbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 advance,
  output ctl_t                 ctl
);

  logic [CFG_W-1:0] src_width;
  logic [CFG_W-1:0] src_height;
  logic [CNT_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  logic [CFG_W-1:0] w;
  logic [CFG_W-1:0] h;
  logic [CFG_W-1:0] w_m1;
  logic [CFG_W-1:0] h_m1;
  logic [CFG_W-1:0] w_even_m1;
  logic [CFG_W-1:0] h_even_m1;
  logic             end_col;
  logic             end_row;
  logic             wide;
  logic             tall;

  // Effective size: zero reads as one, large values saturate
  always_comb begin
    if (src_width == '0) begin
      w = CFG_W'(1);
    end else if (src_width > MAX_W_CFG) begin
      w = MAX_W_CFG;
    end else begin
      w = src_width;
    end
    if (src_height == '0) begin
      h = CFG_W'(1);
    end else if (src_height > MAX_H_CFG) begin
      h = MAX_H_CFG;
    end else begin
      h = src_height;
    end
  end

  // Position decode
  always_comb begin
    w_m1      = w - CFG_W'(1);
    h_m1      = h - CFG_W'(1);
    w_even_m1 = {w[CFG_W-1:1], 1'b0} - CFG_W'(1);
    h_even_m1 = {h[CFG_W-1:1], 1'b0} - CFG_W'(1);
    end_col   = (CFG_W'(column_count) == w_m1);
    end_row   = (CFG_W'(row_count) == h_m1);
    wide      = (w[CFG_W-1:1] != '0);
    tall      = (h[CFG_W-1:1] != '0);

    if (wide && tall) begin
      ctl.mode = MODE_QUAD;
    end else if (wide) begin
      ctl.mode = MODE_ROW;
    end else if (tall) begin
      ctl.mode = MODE_COL;
    end else begin
      ctl.mode = MODE_PASS;
    end
    ctl.x_odd    = column_count[0];
    ctl.y_odd    = row_count[0];
    ctl.col_keep = !(w[0] && end_col);
    ctl.row_keep = !(h[0] && end_row);
    ctl.last_x   = (CFG_W'(column_count) == w_even_m1);
    ctl.last_y   = (CFG_W'(row_count) == h_even_m1);
    ctl.idx      = column_count[CNT_W-1:1];
  end

  // Size registers and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= MAX_W_CFG;
      src_height   <= MAX_H_CFG;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH: begin
          src_width    <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        CFG_SRC_HEIGHT: begin
          src_height   <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      if (end_col) begin
        column_count <= '0;
        if (end_row) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
        end
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/mip_box_downsample_rgba.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_box_downsample_rgba: 2x2 box-filter mip level downsampler, RGBA8
// Pipeline: a result item goes through stage 1 and then the output register.
// Throughput is one source item per cycle while src_stall is low, set by the
// single line buffer port (one read or write per item).
// Reset: size registers go to 2048x2048 and the raster position to the first
// pixel. The line buffer is not cleared; rows read only what the row before
// them wrote.
// ----------------------------------------------------------------------------
module mip_box_downsample_rgba
  import mbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  logic [PIX_W-1:0]     src_pixel,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output logic [PIX_W-1:0]     dst_pixel,
  output logic                 level_done
);

  ctl_t             ctl;
  logic             accept;
  logic             out_free;
  logic [PIX_W-1:0] pair_first_pixel;
  logic [PIX_W-1:0] column_one_hold;
  logic [SUM_W-1:0] h_sum;
  logic             ram_we;
  logic             ram_re;
  logic [SUM_W-1:0] ram_rdata;

  // Result generated at accept time
  logic             prod;
  logic             prod_quad;
  logic             prod_done;
  logic [PIX_W-1:0] prod_pix;

  // Stage 1 (waiting on line buffer read)
  logic             s1_valid;
  logic             s1_quad;
  logic             s1_done;
  logic [SUM_W-1:0] s1_sum;
  logic [PIX_W-1:0] s1_pix;

  assign cfg_ready = 1'b1;
  assign out_free  = !dst_valid || !dst_stall;
  assign src_stall = s1_valid && !out_free;
  assign accept    = src_valid && !src_stall;

  mbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .ctl       (ctl)
  );

  // Decode what this item does
  always_comb begin
    h_sum     = add_pair(pair_first_pixel, src_pixel);
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    prod      = 1'b0;
    prod_quad = 1'b0;
    prod_done = 1'b0;
    prod_pix  = src_pixel;
    unique case (ctl.mode)
      MODE_QUAD: begin
        if (ctl.col_keep && ctl.row_keep && ctl.x_odd) begin
          if (ctl.y_odd) begin
            ram_re    = accept;
            prod      = 1'b1;
            prod_quad = 1'b1;
            prod_done = ctl.last_x && ctl.last_y;
          end else begin
            ram_we = accept;
          end
        end
      end
      MODE_ROW: begin
        if (ctl.col_keep && ctl.x_odd) begin
          prod      = 1'b1;
          prod_done = ctl.last_x;
          prod_pix  = pair_avg(pair_first_pixel, src_pixel);
        end
      end
      MODE_COL: begin
        if (ctl.row_keep && ctl.y_odd) begin
          prod      = 1'b1;
          prod_done = ctl.last_y;
          prod_pix  = pair_avg(column_one_hold, src_pixel);
        end
      end
      MODE_PASS: begin
        prod      = 1'b1;
        prod_done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mbd_line_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (SUM_W)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ctl.idx),
    .wdata (h_sum),
    .rdata (ram_rdata)
  );

  // Held pixels for the pair in progress
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_first_pixel <= '0;
      column_one_hold  <= '0;
    end else if (accept) begin
      if ((ctl.mode == MODE_QUAD && ctl.col_keep && ctl.row_keep && !ctl.x_odd) ||
          (ctl.mode == MODE_ROW && ctl.col_keep && !ctl.x_odd)) begin
        pair_first_pixel <= src_pixel;
      end
      if (ctl.mode == MODE_COL && ctl.row_keep && !ctl.y_odd) begin
        column_one_hold <= src_pixel;
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!src_stall) begin
      s1_valid <= accept && prod;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept && prod) begin
      s1_quad <= prod_quad;
      s1_done <= prod_done;
      s1_sum  <= h_sum;
      s1_pix  <= prod_pix;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_free) begin
      dst_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      dst_pixel  <= s1_quad ? quad_avg(ram_rdata, s1_sum) : s1_pix;
      level_done <= s1_done;
    end
  end

endmodule
